/* rtl/core/spnctr_pkg.sv */
// package: widths, cipher tables and gf(2^8) helper for the counter mode cipher
package spnctr_pkg;

  localparam int DATA_W    = 64;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 4;
  localparam int BLK_W     = 128;
  localparam int NBYTES    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 4'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [7:0] GF_POLY = 8'hC3;

  localparam logic [7:0] LCOEF [16] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hFC, 8'hEE, 8'hDD, 8'h11, 8'hCF, 8'h6E, 8'h31, 8'h16,
    8'hFB, 8'hC4, 8'hFA, 8'hDA, 8'h23, 8'hC5, 8'h04, 8'h4D,
    8'hE9, 8'h77, 8'hF0, 8'hDB, 8'h93, 8'h2E, 8'h99, 8'hBA,
    8'h17, 8'h36, 8'hF1, 8'hBB, 8'h14, 8'hCD, 8'h5F, 8'hC1,
    8'hF9, 8'h18, 8'h65, 8'h5A, 8'hE2, 8'h5C, 8'hEF, 8'h21,
    8'h81, 8'h1C, 8'h3C, 8'h42, 8'h8B, 8'h01, 8'h8E, 8'h4F,
    8'h05, 8'h84, 8'h02, 8'hAE, 8'hE3, 8'h6A, 8'h8F, 8'hA0,
    8'h06, 8'h0B, 8'hED, 8'h98, 8'h7F, 8'hD4, 8'hD3, 8'h1F,
    8'hEB, 8'h34, 8'h2C, 8'h51, 8'hEA, 8'hC8, 8'h48, 8'hAB,
    8'hF2, 8'h2A, 8'h68, 8'hA2, 8'hFD, 8'h3A, 8'hCE, 8'hCC,
    8'hB5, 8'h70, 8'h0E, 8'h56, 8'h08, 8'h0C, 8'h76, 8'h12,
    8'hBF, 8'h72, 8'h13, 8'h47, 8'h9C, 8'hB7, 8'h5D, 8'h87,
    8'h15, 8'hA1, 8'h96, 8'h29, 8'h10, 8'h7B, 8'h9A, 8'hC7,
    8'hF3, 8'h91, 8'h78, 8'h6F, 8'h9D, 8'h9E, 8'hB2, 8'hB1,
    8'h32, 8'h75, 8'h19, 8'h3D, 8'hFF, 8'h35, 8'h8A, 8'h7E,
    8'h6D, 8'h54, 8'hC6, 8'h80, 8'hC3, 8'hBD, 8'h0D, 8'h57,
    8'hDF, 8'hF5, 8'h24, 8'hA9, 8'h3E, 8'hA8, 8'h43, 8'hC9,
    8'hD7, 8'h79, 8'hD6, 8'hF6, 8'h7C, 8'h22, 8'hB9, 8'h03,
    8'hE0, 8'h0F, 8'hEC, 8'hDE, 8'h7A, 8'h94, 8'hB0, 8'hBC,
    8'hDC, 8'hE8, 8'h28, 8'h50, 8'h4E, 8'h33, 8'h0A, 8'h4A,
    8'hA7, 8'h97, 8'h60, 8'h73, 8'h1E, 8'h00, 8'h62, 8'h44,
    8'h1A, 8'hB8, 8'h38, 8'h82, 8'h64, 8'h9F, 8'h26, 8'h41,
    8'hAD, 8'h45, 8'h46, 8'h92, 8'h27, 8'h5E, 8'h55, 8'h2F,
    8'h8C, 8'hA3, 8'hA5, 8'h7D, 8'h69, 8'hD5, 8'h95, 8'h3B,
    8'h07, 8'h58, 8'hB3, 8'h40, 8'h86, 8'hAC, 8'h1D, 8'hF7,
    8'h30, 8'h37, 8'h6B, 8'hE4, 8'h88, 8'hD9, 8'hE7, 8'h89,
    8'hE1, 8'h1B, 8'h83, 8'h49, 8'h4C, 8'h3F, 8'hF8, 8'hFE,
    8'h8D, 8'h53, 8'hAA, 8'h90, 8'hCA, 8'hD8, 8'h85, 8'h61,
    8'h20, 8'h71, 8'h67, 8'hA4, 8'h2D, 8'h2B, 8'h09, 8'h5B,
    8'hCB, 8'h9B, 8'h25, 8'hD0, 8'hBE, 8'hE5, 8'h6C, 8'h52,
    8'h59, 8'hA6, 8'h74, 8'hD2, 8'hE6, 8'hF4, 8'hB4, 8'hC0,
    8'hD1, 8'h66, 8'hAF, 8'hC2, 8'h39, 8'h4B, 8'h63, 8'hB6
  };

  localparam logic [7:0] SCHED [8][16] = '{
    '{8'hA3,8'hD6,8'hD9,8'h4F,8'h15,8'hA6,8'hF7,8'h57,
      8'hC1,8'h05,8'hF3,8'h17,8'hB0,8'h3D,8'hB2,8'hC4},
    '{8'hDC,8'h87,8'hEC,8'hE4,8'hD8,8'h90,8'hF4,8'hB3,
      8'hBA,8'h4E,8'hB9,8'h20,8'h79,8'hCB,8'hEB,8'h02},
    '{8'hB2,8'h25,8'h9A,8'h96,8'hB4,8'hD8,8'h8E,8'h0B,
      8'hE7,8'h69,8'h04,8'h30,8'hA4,8'h4F,8'h7F,8'h03},
    '{8'h7B,8'hCD,8'h1B,8'h0B,8'h73,8'hE3,8'h2B,8'hA5,
      8'hB7,8'h9C,8'hB1,8'h40,8'hF2,8'h55,8'h15,8'h04},
    '{8'h15,8'h6F,8'h6D,8'h79,8'h1F,8'hAB,8'h51,8'h1D,
      8'hEA,8'hBB,8'h0C,8'h50,8'h2F,8'hD1,8'h81,8'h05},
    '{8'hA7,8'h4A,8'hF7,8'hEF,8'hAB,8'h73,8'hDF,8'h16,
      8'h0D,8'hD2,8'h08,8'h60,8'h8B,8'h9E,8'hFE,8'h06},
    '{8'hC9,8'hE8,8'h81,8'h9D,8'hC7,8'h3B,8'hA5,8'hAE,
      8'h50,8'hF5,8'hB5,8'h70,8'h56,8'h1A,8'h6A,8'h07},
    '{8'hF6,8'h59,8'h36,8'h16,8'hE6,8'h05,8'h56,8'h89,
      8'hAD,8'hFB,8'hA1,8'h80,8'h27,8'hAA,8'h2A,8'h08}
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY) : {x[6:0], 1'b0};
    end
    return p;
  endfunction

endpackage

/* rtl/core/spnctr_in_if.sv */
// interface: input channel carrying start and data beats
interface spnctr_in_if;
  import spnctr_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [DATA_W-1:0]  data_high;
  logic [DATA_W-1:0]  data_low;
  logic [CNT_W-1:0]   byte_count;
  modport source(output valid, opcode, data_high, data_low, byte_count, input ready);
  modport sink(input valid, opcode, data_high, data_low, byte_count, output ready);
endinterface

/* rtl/core/spnctr_out_if.sv */
// interface: result channel carrying processed beats
interface spnctr_out_if;
  import spnctr_pkg::*;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  out_high;
  logic [DATA_W-1:0]  out_low;
  logic [CNT_W-1:0]   out_count;
  modport source(output valid, out_high, out_low, out_count, input ready);
  modport sink(input valid, out_high, out_low, out_count, output ready);
endinterface

/* rtl/core/spn_block_cipher_ctr.sv */
// top level: byte-serial spn block cipher in counter mode
//
// usage: a beat on in_chan with opcode start loads the 128-bit counter from
// data_high/data_low and derives ten round keys from the four cfg key words;
// its result beat is all zero. a data beat xors the leading byte_count bytes
// with the encrypted counter (count above 16 acts as 16), zeroes the rest,
// then advances the counter; a count of zero gives a zero beat at once.
// every byte step uses one s-box lookup or one gf(2^8) multiply per cycle,
// so a round is a byte-serial substitution pass followed by a linear mix
// of sixteen steps, each over all sixteen bytes. one beat is in work at a
// time; the result sits in an output register and the next beat is taken
// while it waits, and if the receiver stalls the block holds its finished
// result until the register frees. reset clears key words, round keys and
// counter to zero. cfg writes are taken at any edge with cfg_we high while
// out of reset; indexes above three are ignored.
module spn_block_cipher_ctr (
  input  logic                               clk,
  input  logic                               rst_n,
  spnctr_in_if.sink                          in_chan,
  spnctr_out_if.source                       out_chan,
  input  logic                               cfg_we,
  input  logic [spnctr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [spnctr_pkg::DATA_W-1:0]      cfg_data
);
  import spnctr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SX   = 3'd1;
  localparam logic [2:0] ST_LIN  = 3'd2;
  localparam logic [2:0] ST_FINX = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [DATA_W-1:0] key_r [4];
  logic [BLK_W-1:0]  kr_r [10];
  logic [BLK_W-1:0]  kr_nxt [10];
  logic [BLK_W-1:0]  ctr_r, ctr_nxt;
  logic [BLK_W-1:0]  s_r, s_nxt;
  logic [BLK_W-1:0]  din_r, din_nxt;
  logic [BLK_W-1:0]  res_r, res_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              enc_r, enc_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic [3:0]        j_r, j_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [3:0]        rnd_r, rnd_nxt;
  logic              ov_r, ov_nxt;
  logic [BLK_W-1:0]  ob_r, ob_nxt;
  logic [CNT_W-1:0]  oc_r, oc_nxt;

  logic [7:0]        kbyte, sx_byte, term;
  logic [BLK_W-1:0]  ks_masked;
  logic [CNT_W-1:0]  n_clip;
  logic              in_acc, out_free;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_acc             = in_chan.valid && in_chan.ready;
  assign out_free           = !ov_r || out_chan.ready;
  assign out_chan.valid     = ov_r;
  assign out_chan.out_high  = ob_r[BLK_W-1:DATA_W];
  assign out_chan.out_low   = ob_r[DATA_W-1:0];
  assign out_chan.out_count = oc_r;

  assign n_clip  = (in_chan.byte_count > CNT_W'(NBYTES)) ? CNT_W'(NBYTES)
                                                         : in_chan.byte_count;
  assign kbyte   = enc_r ? kr_r[0][BLK_W-1 -: 8] : SCHED[rnd_r[2:0]][j_r];
  assign sx_byte = SBOX[s_r[BLK_W-1 -: 8] ^ kbyte];
  assign term    = gf_mul(s_r[BLK_W-1 -: 8], LCOEF[j_r]);

  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      if (CNT_W'(i) < n_r) ks_masked[BLK_W-1-8*i -: 8] =
        s_r[BLK_W-1-8*i -: 8] ^ kr_r[0][BLK_W-1-8*i -: 8] ^ din_r[BLK_W-1-8*i -: 8];
      else ks_masked[BLK_W-1-8*i -: 8] = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kr_nxt    = kr_r;
    ctr_nxt   = ctr_r;
    s_nxt     = s_r;
    din_nxt   = din_r;
    res_nxt   = res_r;
    n_nxt     = n_r;
    enc_nxt   = enc_r;
    acc_nxt   = acc_r;
    j_nxt     = j_r;
    step_nxt  = step_r;
    rnd_nxt   = rnd_r;
    ov_nxt    = ov_r && !out_chan.ready;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt  = '0;
          n_nxt    = '0;
          j_nxt    = '0;
          step_nxt = '0;
          rnd_nxt  = '0;
          acc_nxt  = '0;
          din_nxt  = {in_chan.data_high, in_chan.data_low};
          if (in_chan.opcode == OP_START) begin
            ctr_nxt = {in_chan.data_high, in_chan.data_low};
            for (int i = 0; i < 8; i++) kr_nxt[i] = kr_r[i+2];
            kr_nxt[8] = {key_r[0], key_r[1]};
            kr_nxt[9] = {key_r[2], key_r[3]};
            s_nxt     = {key_r[0], key_r[1]};
            enc_nxt   = 1'b0;
            state_nxt = ST_SX;
          end else if (n_clip == '0) begin
            state_nxt = ST_FIN;
          end else begin
            n_nxt     = n_clip;
            s_nxt     = ctr_r;
            enc_nxt   = 1'b1;
            state_nxt = ST_SX;
          end
        end
      end
      ST_SX: begin
        s_nxt = {s_r[BLK_W-9:0], sx_byte};
        if (enc_r) kr_nxt[0] = {kr_r[0][BLK_W-9:0], kr_r[0][BLK_W-1 -: 8]};
        j_nxt = j_r + 4'd1;
        if (j_r == 4'd15) state_nxt = ST_LIN;
      end
      ST_LIN: begin
        j_nxt = j_r + 4'd1;
        if (j_r != 4'd15) begin
          s_nxt   = {s_r[BLK_W-9:0], s_r[BLK_W-1 -: 8]};
          acc_nxt = acc_r ^ term;
        end else begin
          s_nxt    = {acc_r ^ term, s_r[BLK_W-9:0]};
          acc_nxt  = '0;
          step_nxt = step_r + 4'd1;
          if (step_r == 4'd15) begin
            rnd_nxt = rnd_r + 4'd1;
            if (enc_r) begin
              for (int i = 0; i < 9; i++) kr_nxt[i] = kr_r[i+1];
              kr_nxt[9] = kr_r[0];
              state_nxt = (rnd_r == 4'd8) ? ST_FINX : ST_SX;
            end else begin
              for (int i = 0; i < 9; i++) kr_nxt[i] = kr_r[i+1];
              kr_nxt[9] = {acc_r ^ term, s_r[BLK_W-9:0]} ^ kr_r[9];
              s_nxt     = kr_r[9];
              state_nxt = (rnd_r == 4'd7) ? ST_FIN : ST_SX;
            end
          end
        end
      end
      ST_FINX: begin
        res_nxt = ks_masked;
        for (int i = 0; i < 9; i++) kr_nxt[i] = kr_r[i+1];
        kr_nxt[9] = kr_r[0];
        ctr_nxt   = ctr_r + BLK_W'(1);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = res_r;
          oc_nxt    = n_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      ctr_r   <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      for (int i = 0; i < 10; i++) kr_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      ctr_r   <= ctr_nxt;
      kr_r    <= kr_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KEY0: key_r[0] <= cfg_data;
          CFG_KEY1: key_r[1] <= cfg_data;
          CFG_KEY2: key_r[2] <= cfg_data;
          CFG_KEY3: key_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    din_r  <= din_nxt;
    res_r  <= res_nxt;
    n_r    <= n_nxt;
    enc_r  <= enc_nxt;
    acc_r  <= acc_nxt;
    j_r    <= j_nxt;
    step_r <= step_nxt;
    rnd_r  <= rnd_nxt;
    ob_r   <= ob_nxt;
    oc_r   <= oc_nxt;
  end

  a_zero_cnt_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oc_r == '0) |-> (ob_r == '0))
    else $error("zero-count beat with nonzero data");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (oc_r <= CNT_W'(NBYTES)))
    else $error("result count above block size");

  a_finx_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINX) |=> (state_r == ST_FIN))
    else $error("final key xor not followed by result hand-off");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("input taken while a beat is in work");

endmodule

/* verif/tb_top.sv */
// testbench for the spn counter mode cipher: random and directed beats checked against a predictor
`timescale 1ns / 100ps
module tb_top;
  import spnctr_pkg::*;

  localparam int DATA_LAT  = 2451;
  localparam int DRAIN_CYC = 3000;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic              op;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [CNT_W-1:0]  cnt;
  } cipher_beat_t;

  typedef struct {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [CNT_W-1:0]  cnt;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  spnctr_in_if in_if ();
  spnctr_out_if out_if ();

  spn_block_cipher_ctr DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  cipher_beat_t pending_beats[$];
  text_beat_t   expected_text[$];
  logic [DATA_W-1:0] key_regs [4];
  logic [BLK_W-1:0]  sched_keys [10];
  logic [BLK_W-1:0]  ctr_value;
  int  mismatches = 0;
  int  n_starts = 0, n_data = 0, n_zero = 0, n_over = 0, n_results = 0;
  bit  no_idle = 1'b0;
  bit  in_took = 1'b0;
  longint cycles = 0;

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'hC3) : {a[6:0], 1'b0};
    end
    return p;
  endfunction

  function automatic logic [BLK_W-1:0] lin_layer(logic [BLK_W-1:0] s);
    logic [7:0] acc;
    for (int r = 0; r < 16; r++) begin
      acc = 8'h00;
      for (int i = 0; i < 16; i++) acc = acc ^ gf_times(s[127-8*i -: 8], LCOEF[i]);
      s = {acc, s[127:8]};
    end
    return s;
  endfunction

  function automatic logic [BLK_W-1:0] lsx(logic [BLK_W-1:0] k, logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    for (int i = 0; i < 16; i++) t[127-8*i -: 8] = SBOX[s[127-8*i -: 8] ^ k[127-8*i -: 8]];
    return lin_layer(t);
  endfunction

  function automatic void expand_keys();
    logic [BLK_W-1:0] c;
    sched_keys[0] = {key_regs[0], key_regs[1]};
    sched_keys[1] = {key_regs[2], key_regs[3]};
    for (int i = 2; i < 10; i++) begin
      for (int j = 0; j < 16; j++) c[127-8*j -: 8] = SCHED[i-2][j];
      sched_keys[i] = lsx(c, sched_keys[i-2]) ^ sched_keys[i-1];
    end
  endfunction

  function automatic text_beat_t cipher_step(cipher_beat_t b);
    text_beat_t r;
    logic [BLK_W-1:0] ks, d;
    int n;
    r = '{hi: '0, lo: '0, cnt: '0};
    if (b.op == OP_START) begin
      ctr_value = {b.hi, b.lo};
      expand_keys();
      return r;
    end
    n = (b.cnt > 16) ? 16 : int'(b.cnt);
    if (n == 0) return r;
    ks = ctr_value;
    for (int i = 0; i < 9; i++) ks = lsx(sched_keys[i], ks);
    ks = ks ^ sched_keys[9];
    d = {b.hi, b.lo} ^ ks;
    for (int i = n; i < 16; i++) d[127-8*i -: 8] = 8'h00;
    ctr_value = ctr_value + BLK_W'(1);
    r.hi = d[127:64];
    r.lo = d[63:0];
    r.cnt = CNT_W'(n);
    return r;
  endfunction

  task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // input side: predict on each accepted beat
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
    in_took <= in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      cipher_beat_t b;
      b = '{op: in_if.opcode, hi: in_if.data_high, lo: in_if.data_low, cnt: in_if.byte_count};
      if (b.op == OP_START) n_starts++;
      else if (b.cnt == 0) n_zero++;
      else begin
        n_data++;
        if (b.cnt > 16) n_over++;
      end
      expected_text.push_back(cipher_step(b));
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      text_beat_t w;
      n_results++;
      if (expected_text.size() == 0) begin
        report("unexpected beat", out_if.out_high, '0);
      end else begin
        w = expected_text.pop_front();
        if (out_if.out_high !== w.hi) report("out_high", out_if.out_high, w.hi);
        if (out_if.out_low !== w.lo) report("out_low", out_if.out_low, w.lo);
        if (out_if.out_count !== w.cnt)
          report("out_count", DATA_W'(out_if.out_count), DATA_W'(w.cnt));
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_START;
    in_if.data_high = '0;
    in_if.data_low = '0;
    in_if.byte_count = '0;
    out_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_if.valid || in_took) begin
        if (pending_beats.size() > 0 && (no_idle || $urandom_range(0, 99) >= 6)) begin
          cipher_beat_t b;
          b = pending_beats.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= b.op;
          in_if.data_high <= b.hi;
          in_if.data_low <= b.lo;
          in_if.byte_count <= b.cnt;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= no_idle || $urandom_range(0, 99) >= 6;
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 14) return CNT_W'($urandom_range(17, 31));
    if (r < 50) return CNT_W'(16);
    return CNT_W'($urandom_range(1, 15));
  endfunction

  task automatic push(logic op, logic [DATA_W-1:0] hi, logic [DATA_W-1:0] lo,
                      logic [CNT_W-1:0] cnt);
    pending_beats.push_back('{op: op, hi: hi, lo: lo, cnt: cnt});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx <= CFG_KEY3) key_regs[idx[1:0]] = val;
  endtask

  task automatic load_key(int kind);
    logic [DATA_W-1:0] v;
    for (int i = 0; i < 4; i++) begin
      v = (kind == 0) ? '0 : (kind == 1) ? '1 : rand64();
      write_reg(CFG_IDX_W'(i), v);
    end
    write_reg(CFG_IDX_W'($urandom_range(4, 15)), rand64());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_if.valid || expected_text.size() > 0)
      @(negedge clk);
    repeat (DATA_LAT + 50) @(negedge clk);
  endtask

  initial begin
    int budget;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    for (int i = 0; i < 10; i++) sched_keys[i] = '0;
    ctr_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: data before any start, count edges, counter carries, extreme fields
    push(OP_DATA, '1, '1, CNT_W'(16));
    push(OP_DATA, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, CNT_W'(0));
    push(OP_START, '0, '0, CNT_W'(31));
    push(OP_DATA, '0, '0, CNT_W'(16));
    push(OP_DATA, '1, '1, CNT_W'(1));
    push(OP_DATA, '1, '0, CNT_W'(17));
    push(OP_DATA, '0, '1, CNT_W'(31));
    push(OP_DATA, '1, '1, CNT_W'(0));
    push(OP_DATA, 64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A, CNT_W'(8));
    push(OP_DATA, '1, '1, CNT_W'(15));
    drain();
    load_key(1);
    push(OP_START, '1, '1, CNT_W'(0));
    push(OP_DATA, '1, '1, CNT_W'(16));
    push(OP_DATA, '0, '0, CNT_W'(16));
    push(OP_START, 64'h0000000000000007, '1, CNT_W'(16));
    push(OP_DATA, '1, '1, CNT_W'(9));
    push(OP_DATA, '1, '1, CNT_W'(16));
    drain();

    // random phases: well-formed messages with stray data and repeated starts
    for (int ph = 0; ph < 6; ph++) begin
      load_key(ph == 0 ? 0 : ph == 3 ? 1 : 2);
      no_idle = (ph == 2);
      budget = 230;
      while (budget > 0) begin
        int len;
        if ($urandom_range(0, 9) != 0) begin
          logic [DATA_W-1:0] ivl;
          ivl = ($urandom_range(0, 7) == 0) ? ~64'($urandom_range(0, 3)) : rand64();
          push(OP_START, rand64(), ivl, CNT_W'($urandom_range(0, 31)));
          budget--;
        end
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) push(OP_DATA, rand64(), rand64(), rand_count());
        budget -= len;
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYC) @(negedge clk);
    $display("covered %0d starts, %0d data beats (%0d over sixteen), %0d zero-count beats",
             n_starts, n_data, n_over, n_zero);
    $display("%0d result beats checked across 8 key settings, %0d mismatches",
             n_results, mismatches);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
